// ===== hw/rtl/s2i_pkg.sv =====
// Shared types and character constants for the string to integer converter.
package s2i_pkg;

  localparam int unsigned ChW  = 8;
  localparam int unsigned OutW = 32;

  // Character codes used by the prefix and digit decode.
  localparam logic [ChW-1:0] CharNul     = 8'h00;
  localparam logic [ChW-1:0] CharMinus   = 8'h2D;
  localparam logic [ChW-1:0] CharZero    = 8'h30;
  localparam logic [ChW-1:0] CharNine    = 8'h39;
  localparam logic [ChW-1:0] CharLowA    = 8'h61;
  localparam logic [ChW-1:0] CharLowF    = 8'h66;
  localparam logic [ChW-1:0] CharLowX    = 8'h78;
  localparam logic [ChW-1:0] CaseBit     = 8'h20;
  // Subtracting this from a lowercase letter gives its hex digit value.
  localparam logic [ChW-1:0] HexLetterOfs = 8'h57;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_ZERO  = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_e;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
  } beat_t;

  typedef struct packed {
    phase_e phase;
    base_e  base;
    logic   negative;
  } ctl_t;

  localparam ctl_t CtlReset = '{phase: PH_START, base: BASE_DEC, negative: 1'b0};

endpackage

// ===== hw/rtl/s2i_in_stage.sv =====
// Input register stage: captures one character beat and holds it until it is processed.
module s2i_in_stage
  import s2i_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  beat_t s_beat_i,
  input  logic  take_i,
  output logic  valid_o,
  output beat_t beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      beat_q <= s_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== hw/rtl/s2i_step.sv =====
// Per-character update: prefix and sign handling, digit decode and accumulate, end of string.
module s2i_step
  import s2i_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  ctl_t                   ctl_i,
  input  logic [VALUE_WIDTH-1:0] acc_i,
  input  beat_t                  beat_i,
  output ctl_t                   ctl_o,
  output logic [VALUE_WIDTH-1:0] acc_o,
  output logic                   fin_o,
  output logic [OutW-1:0]        value_o
);

  localparam int unsigned ExtW = (VALUE_WIDTH > OutW) ? VALUE_WIDTH : OutW;

  logic [ChW-1:0]         ch, lower;
  logic                   is_dec, is_hex_letter, take, digit_ok;
  logic [3:0]             digit;
  ctl_t                   ctl_n;
  logic [VALUE_WIDTH-1:0] scaled, acc_n, signed_val;
  logic [ExtW-1:0]        ext_val;

  assign ch            = beat_i.ch;
  assign lower         = ch | CaseBit;
  assign is_dec        = (ch >= CharZero) && (ch <= CharNine);
  assign is_hex_letter = (lower >= CharLowA) && (lower <= CharLowF);
  assign digit         = is_dec ? 4'(ch - CharZero) : 4'(lower - HexLetterOfs);

  always_comb begin
    ctl_n = ctl_i;
    take  = 1'b0;
    if (ch != CharNul) begin
      unique case (ctl_i.phase)
        PH_START, PH_SIGN: begin
          if ((ctl_i.phase == PH_START) && (ch == CharMinus)) begin
            ctl_n.negative = 1'b1;
            ctl_n.phase    = PH_SIGN;
          end else if (ch == CharZero) begin
            ctl_n.phase = PH_ZERO;
          end else begin
            ctl_n.base  = BASE_DEC;
            ctl_n.phase = PH_BODY;
            take        = 1'b1;
          end
        end
        PH_ZERO: begin
          ctl_n.phase = PH_BODY;
          if (lower == CharLowX) begin
            ctl_n.base = BASE_HEX;
          end else begin
            ctl_n.base = BASE_OCT;
            take       = 1'b1;
          end
        end
        PH_BODY: begin
          take = 1'b1;
        end
        default: begin
          ctl_n = CtlReset;
        end
      endcase
    end
  end

  // Octal mode still takes 8 and 9 as digits; letters only count in hex mode.
  assign digit_ok = take && (is_dec || ((ctl_n.base == BASE_HEX) && is_hex_letter));

  always_comb begin
    unique case (ctl_n.base)
      BASE_HEX: scaled = acc_i << 4;
      BASE_OCT: scaled = acc_i << 3;
      default:  scaled = (acc_i << 3) + (acc_i << 1);
    endcase
  end

  assign acc_n      = digit_ok ? (scaled + VALUE_WIDTH'(digit)) : acc_i;
  assign fin_o      = beat_i.last || (ch == CharNul);
  assign signed_val = ctl_n.negative ? (VALUE_WIDTH'(0) - acc_n) : acc_n;
  assign ext_val    = ExtW'(signed_val);
  assign value_o    = ext_val[OutW-1:0];

  assign ctl_o = fin_o ? CtlReset : ctl_n;
  assign acc_o = fin_o ? '0 : acc_n;

endmodule

// ===== hw/rtl/string_to_integer_auto_radix_core.sv =====
// Top level of the streaming ASCII string to signed integer converter.
//
// The block takes one ASCII character per input beat and returns one 32-bit
// two's complement value per string. A leading '-' negates the result; after
// it, "0x" or "0X" selects hexadecimal, a lone leading '0' selects octal, and
// anything else selects decimal. Every digit of the current base updates the
// accumulator as acc * base + digit, wrapping modulo 2^VALUE_WIDTH; characters
// that are not digits are skipped. In octal mode '8' and '9' are still taken
// with their face values, and hex letters are accepted in either case. A NUL
// character, or a beat with tlast set, ends the string: a non-NUL last
// character is processed first, and then the result beat is produced and the
// parser returns to the start of a new string. When VALUE_WIDTH is below 32
// the result is zero extended; above 32 its low 32 bits are returned.
// One character is accepted per clock cycle unless a string's end is stalled:
// a beat is captured in the input register, the shift-add update then runs
// combinationally from that register and the parser state register, and a
// string's result is loaded into the output register when its final beat
// leaves the input register, and is offered from there. The input side keeps accepting while a
// result waits in the output register; it stalls only when a string ends and
// the output register is still held by the sink.
module string_to_integer_auto_radix_core
  import s2i_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [ChW-1:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic            s_axis_tlast_i,   // last
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o    // [31:0] value (signed)
);

  beat_t                  in_beat, cur_beat;
  logic                   cur_valid, take, fin, out_free;
  ctl_t                   ctl_q, ctl_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [OutW-1:0]        value;
  logic                   m_valid_q, m_valid_d;
  logic [OutW-1:0]        m_data_q;

  assign in_beat = '{ch: s_axis_tdata_i, last: s_axis_tlast_i};

  s2i_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_beat_i  (in_beat),
    .take_i    (take),
    .valid_o   (cur_valid),
    .beat_o    (cur_beat)
  );

  s2i_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .ctl_i   (ctl_q),
    .acc_i   (acc_q),
    .beat_i  (cur_beat),
    .ctl_o   (ctl_d),
    .acc_o   (acc_d),
    .fin_o   (fin),
    .value_o (value)
  );

  // A character that ends a string needs the output register to be free.
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign take     = cur_valid && (!fin || out_free);

  always_comb begin
    m_valid_d = m_valid_q;
    if (take && fin) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q     <= CtlReset;
      acc_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      if (take) begin
        ctl_q <= ctl_d;
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && fin) begin
      m_data_q <= value;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== hw/rtl/s2i_checker.sv =====
// Port-level checks for the string to integer converter, bound to the top level.
module s2i_checker
  import s2i_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid_i,
  input logic            s_axis_tready_o,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o
);

  // A result beat held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // With the output register empty, nothing can hold back the input side.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  // A fresh result follows the beat that ended the string through the input register and the output register.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result beat without an accepted input beat");

endmodule

bind string_to_integer_auto_radix_core s2i_checker u_s2i_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
